### sv/assert_macros.svh
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define UGCM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define UGCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UGCM_ASSERT(label, ante, cons, msg)

`define UGCM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### sv/ugcm_pkg.sv
package ugcm_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int COORD_W   = 24;
    localparam int CS_W      = COORD_W - 1;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int COUNT_W   = CELL_W + 1;
    localparam int EXT_W     = COORD_W + 2;
    localparam int OFF_W     = COORD_W + 2;
    localparam int DIV_W     = CS_W + CELL_W + 1;
    localparam int BIT_W     = $clog2(CELL_W + 1);
    localparam int INDEX_W   = 24;
    localparam int IDX_W     = 3;
    localparam int LANES     = 4;
    localparam int QDEPTH    = 2;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_MIN_X = IDX_W'(0);
    localparam reg_idx_t REG_MIN_Y = IDX_W'(1);
    localparam reg_idx_t REG_MAX_X = IDX_W'(2);
    localparam reg_idx_t REG_MAX_Y = IDX_W'(3);
    localparam reg_idx_t REG_CELL  = IDX_W'(4);

    localparam logic signed [COORD_W-1:0] RST_MIN_X = COORD_W'(0);
    localparam logic signed [COORD_W-1:0] RST_MIN_Y = COORD_W'(0);
    localparam logic signed [COORD_W-1:0] RST_MAX_X = COORD_W'(1048576);
    localparam logic signed [COORD_W-1:0] RST_MAX_Y = COORD_W'(1048576);
    localparam logic [CS_W-1:0]           RST_CELL  = CS_W'(256);

    typedef enum logic [1:0] {
        FN_POINT  = 2'd0,
        FN_BOX    = 2'd1,
        FN_CIRCLE = 2'd2,
        FN_INDEX  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_RUN
    } cfg_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic [CS_W-1:0]           cell_size;
        logic [COUNT_W-1:0]        cols;
        logic [COUNT_W-1:0]        rows;
        logic                      busy;
    } cfg_t;

    typedef struct packed {
        logic                        miss;
        logic                        direct;
        logic [LANES-1:0][OFF_W-1:0] off;
        logic [CELL_W-1:0]           dcol;
        logic [CELL_W-1:0]           drow;
    } fe_t;

    typedef struct packed {
        logic                         valid;
        logic                         miss;
        logic                         direct;
        logic [LANES-1:0][DIV_W-1:0]  rem;
        logic [LANES-1:0][CELL_W-1:0] q;
        logic [LANES-1:0]             sat;
        logic [CELL_W-1:0]            dcol;
        logic [CELL_W-1:0]            drow;
    } st_t;

    typedef struct packed {
        logic             take;
        logic [DIV_W-1:0] rem;
    } div_t;

    function automatic div_t div_bit(logic [DIV_W-1:0] rem, logic [CS_W-1:0] d,
                                     logic [BIT_W-1:0] b);
        logic [DIV_W-1:0] sh;
        div_t             r;
        sh     = DIV_W'(d) << b;
        r.take = (rem >= sh);
        r.rem  = r.take ? rem - sh : rem;
        return r;
    endfunction

    // quotient would reach MAX_CELLS or more
    function automatic logic sat_check(logic [DIV_W-1:0] rem, logic [CS_W-1:0] d);
        return rem >= (DIV_W'(d) << CELL_W);
    endfunction

endpackage

### sv/ugcm_cfg.sv
module ugcm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  ugcm_pkg::reg_idx_t             cfg_index,
    input  logic [ugcm_pkg::COORD_W-1:0]   cfg_data,
    output ugcm_pkg::cfg_t                 cfg
);
    import ugcm_pkg::*;

    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [CS_W-1:0]           cs_reg;
    logic [CS_W-1:0]           cs_eff;
    logic [COUNT_W-1:0]        cols_reg, rows_reg;
    cfg_state_t                state_reg, state_next;
    logic [BIT_W-1:0]          bit_reg;
    logic [DIV_W-1:0]          rem_x_reg, rem_y_reg;
    logic [CELL_W-1:0]         q_x_reg, q_y_reg, q_x_next, q_y_next;
    logic                      sat_x_reg, sat_y_reg, one_x_reg, one_y_reg;
    logic                      wr_hit;
    logic signed [EXT_W-1:0]   ext_x, ext_y;
    logic                      one_x, one_y;
    logic [DIV_W-1:0]          v_x, v_y;
    div_t                      dx, dy;

    assign wr_hit = cfg_write && (cfg_index <= REG_CELL);
    assign cs_eff = (cs_reg == '0) ? CS_W'(1) : cs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= RST_MIN_X;
            min_y_reg <= RST_MIN_Y;
            max_x_reg <= RST_MAX_X;
            max_y_reg <= RST_MAX_Y;
            cs_reg    <= RST_CELL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                REG_CELL:  cs_reg    <= cfg_data[CS_W-1:0];
                default:   ;
            endcase
        end
    end

    // extent of the area, count is one when empty
    always_comb
    begin
        ext_x = EXT_W'(max_x_reg) - EXT_W'(min_x_reg);
        ext_y = EXT_W'(max_y_reg) - EXT_W'(min_y_reg);
        one_x = (ext_x <= 0);
        one_y = (ext_y <= 0);
        v_x   = one_x ? '0 : DIV_W'(unsigned'(ext_x - EXT_W'(1)));
        v_y   = one_y ? '0 : DIV_W'(unsigned'(ext_y - EXT_W'(1)));
        dx    = div_bit(rem_x_reg, cs_eff, bit_reg);
        dy    = div_bit(rem_y_reg, cs_eff, bit_reg);
        q_x_next = q_x_reg | (CELL_W'(dx.take) << bit_reg);
        q_y_next = q_y_reg | (CELL_W'(dy.take) << bit_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CFG_IDLE: if (wr_hit) state_next = CFG_LOAD;
            CFG_LOAD: state_next = wr_hit ? CFG_LOAD : CFG_RUN;
            CFG_RUN:
            begin
                if (wr_hit)
                    state_next = CFG_LOAD;
                else if (bit_reg == '0)
                    state_next = CFG_IDLE;
            end
            default: state_next = CFG_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CFG_LOAD;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COUNT_W'(MAX_CELLS);
            rows_reg <= COUNT_W'(MAX_CELLS);
        end
        else if (state_reg == CFG_RUN && !wr_hit && bit_reg == '0)
        begin
            cols_reg <= one_x_reg ? COUNT_W'(1) :
                        sat_x_reg ? COUNT_W'(MAX_CELLS) : COUNT_W'(q_x_next) + COUNT_W'(1);
            rows_reg <= one_y_reg ? COUNT_W'(1) :
                        sat_y_reg ? COUNT_W'(MAX_CELLS) : COUNT_W'(q_y_next) + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CFG_LOAD)
        begin
            rem_x_reg <= v_x;
            rem_y_reg <= v_y;
            sat_x_reg <= sat_check(v_x, cs_eff);
            sat_y_reg <= sat_check(v_y, cs_eff);
            one_x_reg <= one_x;
            one_y_reg <= one_y;
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            bit_reg   <= BIT_W'(CELL_W - 1);
        end
        else if (state_reg == CFG_RUN)
        begin
            rem_x_reg <= dx.rem;
            rem_y_reg <= dy.rem;
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            bit_reg   <= bit_reg - BIT_W'(1);
        end
    end

    always_comb
    begin
        cfg.min_x     = min_x_reg;
        cfg.min_y     = min_y_reg;
        cfg.max_x     = max_x_reg;
        cfg.max_y     = max_y_reg;
        cfg.cell_size = cs_eff;
        cfg.cols      = cols_reg;
        cfg.rows      = rows_reg;
        cfg.busy      = (state_reg != CFG_IDLE);
    end

endmodule

### sv/ugcm_front.sv
module ugcm_front (
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  first_x,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  first_y,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  second_x,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  second_y,
    input  logic [ugcm_pkg::CS_W-1:0]            radius,
    input  ugcm_pkg::cfg_t                       cfg,
    input  logic                                 q_full,
    output logic                                 push,
    output ugcm_pkg::fe_t                        rec
);
    import ugcm_pkg::*;

    logic signed [EXT_W-1:0] fx, fy, sx, sy, rr;
    logic signed [EXT_W-1:0] bx0, by0, bx1, by1;
    logic signed [EXT_W-1:0] mnx, mny, mxx, mxy;
    logic signed [EXT_W-1:0] cmaxs, rmaxs;
    logic [COUNT_W-1:0]      cmax, rmax;
    logic                    is_box;

    function automatic logic [OFF_W-1:0] clip_off(logic signed [EXT_W-1:0] pos,
                                                  logic signed [EXT_W-1:0] lo);
        logic signed [EXT_W:0] o;
        o = (EXT_W+1)'(pos) - (EXT_W+1)'(lo);
        return (o < 0) ? '0 : OFF_W'(o);
    endfunction

    assign in_stall = q_full || cfg.busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        fx  = EXT_W'(first_x);
        fy  = EXT_W'(first_y);
        sx  = EXT_W'(second_x);
        sy  = EXT_W'(second_y);
        rr  = $signed(EXT_W'(radius));
        mnx = EXT_W'(cfg.min_x);
        mny = EXT_W'(cfg.min_y);
        mxx = EXT_W'(cfg.max_x);
        mxy = EXT_W'(cfg.max_y);
        bx0 = fx;
        by0 = fy;
        bx1 = fx;
        by1 = fy;
        is_box = 1'b0;
        unique case (func_t'(func))
            FN_BOX:
            begin
                bx1    = sx;
                by1    = sy;
                is_box = 1'b1;
            end
            FN_CIRCLE:
            begin
                bx0    = fx - rr;
                by0    = fy - rr;
                bx1    = fx + rr;
                by1    = fy + rr;
                is_box = 1'b1;
            end
            default: ;
        endcase

        cmax  = cfg.cols - COUNT_W'(1);
        rmax  = cfg.rows - COUNT_W'(1);
        cmaxs = $signed(EXT_W'(cmax));
        rmaxs = $signed(EXT_W'(rmax));

        rec.miss   = is_box && (bx1 < mnx || bx0 > mxx || by1 < mny || by0 > mxy);
        rec.direct = (func_t'(func) == FN_INDEX);
        rec.off[0] = clip_off(bx0, mnx);
        rec.off[1] = clip_off(by0, mny);
        rec.off[2] = clip_off(bx1, mnx);
        rec.off[3] = clip_off(by1, mny);
        rec.dcol   = (fx < 0) ? '0 : (fx > cmaxs) ? cmax[CELL_W-1:0] : fx[CELL_W-1:0];
        rec.drow   = (fy < 0) ? '0 : (fy > rmaxs) ? rmax[CELL_W-1:0] : fy[CELL_W-1:0];
    end

endmodule

### sv/ugcm_queue.sv
module ugcm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ugcm_pkg::fe_t wdata,
    input  logic          pop,
    output logic          rd_valid,
    output ugcm_pkg::fe_t rdata,
    output logic          full
);
    import ugcm_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    fe_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_pop;

    assign rd_valid = (cnt_reg != '0);
    assign full     = (cnt_reg == CNT_W'(QDEPTH));
    assign rdata    = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### sv/ugcm_back.sv
module ugcm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ugcm_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    input  ugcm_pkg::fe_t                     q_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              in_range,
    output logic [ugcm_pkg::CELL_W-1:0]       low_col,
    output logic [ugcm_pkg::CELL_W-1:0]       low_row,
    output logic [ugcm_pkg::CELL_W-1:0]       high_col,
    output logic [ugcm_pkg::CELL_W-1:0]       high_row,
    output logic [ugcm_pkg::INDEX_W-1:0]      low_index,
    output logic [ugcm_pkg::INDEX_W-1:0]      high_index
);
    import ugcm_pkg::*;

    localparam int PROD_W = CELL_W + COUNT_W + 1;

    st_t                          st_reg [CELL_W+1];
    st_t                          st0_next;
    st_t                          stp [CELL_W+1];
    logic                         en;
    logic                         cl_valid_reg, cl_miss_reg;
    logic [LANES-1:0][CELL_W-1:0] cl_reg, cl_next;
    logic                         out_valid_reg;
    logic [COUNT_W-1:0]           cmax, rmax;
    logic [CELL_W-1:0]            lim;

    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en && q_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        st0_next.valid  = q_valid;
        st0_next.miss   = q_data.miss;
        st0_next.direct = q_data.direct;
        st0_next.dcol   = q_data.dcol;
        st0_next.drow   = q_data.drow;
        st0_next.q      = '0;
        for (int l = 0; l < LANES; l++)
        begin
            st0_next.rem[l] = DIV_W'(q_data.off[l]);
            st0_next.sat[l] = sat_check(DIV_W'(q_data.off[l]), cfg.cell_size);
        end
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        div_t dv;
        stp[0] = st0_next;
        for (int k = 1; k <= CELL_W; k++)
        begin
            stp[k] = st_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                dv = div_bit(st_reg[k-1].rem[l], cfg.cell_size, BIT_W'(CELL_W - k));
                stp[k].rem[l][CELL_W - k] = 1'b0;
                stp[k].rem[l]              = dv.rem;
                stp[k].q[l][CELL_W - k]    = dv.take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CELL_W; k++)
                st_reg[k] <= '0;
        end
        else if (en)
        begin
            for (int k = 0; k <= CELL_W; k++)
                st_reg[k] <= stp[k];
        end
    end

    // clamp to the grid; a miss gives zero and a direct index passes as given
    always_comb
    begin
        cmax = cfg.cols - COUNT_W'(1);
        rmax = cfg.rows - COUNT_W'(1);
        lim  = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lim = (l % 2 == 0) ? cmax[CELL_W-1:0] : rmax[CELL_W-1:0];
            if (st_reg[CELL_W].miss)
                cl_next[l] = '0;
            else if (st_reg[CELL_W].direct)
                cl_next[l] = (l % 2 == 0) ? st_reg[CELL_W].dcol : st_reg[CELL_W].drow;
            else if (st_reg[CELL_W].sat[l] || st_reg[CELL_W].q[l] > lim)
                cl_next[l] = lim;
            else
                cl_next[l] = st_reg[CELL_W].q[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cl_valid_reg  <= st_reg[CELL_W].valid;
            out_valid_reg <= cl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_miss_reg <= st_reg[CELL_W].miss;
            cl_reg      <= cl_next;
            in_range    <= !cl_miss_reg;
            low_col     <= cl_reg[0];
            low_row     <= cl_reg[1];
            high_col    <= cl_reg[2];
            high_row    <= cl_reg[3];
            low_index   <= INDEX_W'(PROD_W'(cl_reg[1]) * PROD_W'(cfg.cols)
                                    + PROD_W'(cl_reg[0]));
            high_index  <= INDEX_W'(PROD_W'(cl_reg[3]) * PROD_W'(cfg.cols)
                                    + PROD_W'(cl_reg[2]));
        end
    end

endmodule

### sv/uniform_grid_cell_mapper.sv
// Uniform grid cell mapper. Takes one item per cycle while the input is not
// stalled and returns one result per item, in order. The cell divider pipeline
// has one stage per quotient bit (12) plus entry, clamp and index stages. A
// two-entry queue between the input classifier and the divider pipeline lets
// the input keep flowing for two items while the output is stalled. After reset
// and after every write to registers 0 to 4 the column and row counts are
// recomputed by a serial divider for each axis, during which the input stalls;
// register writes are taken at any time.
`include "assert_macros.svh"

module uniform_grid_cell_mapper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ugcm_pkg::IDX_W-1:0]           cfg_index,
    input  logic [ugcm_pkg::COORD_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  first_x,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  first_y,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  second_x,
    input  logic signed [ugcm_pkg::COORD_W-1:0]  second_y,
    input  logic [ugcm_pkg::CS_W-1:0]            radius,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 in_range,
    output logic [ugcm_pkg::CELL_W-1:0]          low_col,
    output logic [ugcm_pkg::CELL_W-1:0]          low_row,
    output logic [ugcm_pkg::CELL_W-1:0]          high_col,
    output logic [ugcm_pkg::CELL_W-1:0]          high_row,
    output logic [ugcm_pkg::INDEX_W-1:0]         low_index,
    output logic [ugcm_pkg::INDEX_W-1:0]         high_index
);
    import ugcm_pkg::*;

    cfg_t cfg;
    fe_t  fe_rec, q_rec;
    logic push, pop, q_valid, q_full;

    ugcm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ugcm_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .radius   (radius),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .rec      (fe_rec)
    );

    ugcm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (fe_rec),
        .pop      (pop),
        .rd_valid (q_valid),
        .rdata    (q_rec),
        .full     (q_full)
    );

    ugcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_data     (q_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .in_range   (in_range),
        .low_col    (low_col),
        .low_row    (low_row),
        .high_col   (high_col),
        .high_row   (high_row),
        .low_index  (low_index),
        .high_index (high_index)
    );

    `UGCM_ASSERT(a_busy_stalls, cfg.busy, in_stall, "input taken during count update")
    `UGCM_ASSERT_NEXT(a_write_busy, cfg_write && (cfg_index <= REG_CELL), cfg.busy,
        "register write did not start count update")
    `UGCM_ASSERT(a_miss_zero, out_valid && !in_range,
        low_col == '0 && high_row == '0 && low_index == '0 && high_index == '0,
        "box outside area gave non-zero cells")

endmodule

### tb/sv/uniform_grid_cell_mapper_tb.sv
module uniform_grid_cell_mapper_tb;
    import ugcm_pkg::*;

    typedef struct {
        func_t                     fn;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic [CS_W-1:0]           rad;
    } query_t;

    typedef struct {
        logic               in_range;
        logic [CELL_W-1:0]  lc;
        logic [CELL_W-1:0]  lr;
        logic [CELL_W-1:0]  hc;
        logic [CELL_W-1:0]  hr;
        logic [INDEX_W-1:0] li;
        logic [INDEX_W-1:0] hi;
    } cell_span_t;

    class grid_scoreboard;
        longint     min_x, min_y, max_x, max_y, cell_size;
        longint     cols, rows;
        cell_span_t spans_due[$];
        int         errors, matched, misses;

        function new();
            min_x     = 0;
            min_y     = 0;
            max_x     = 1048576;
            max_y     = 1048576;
            cell_size = 256;
            recount();
        endfunction

        function longint step_size();
            return cell_size == 0 ? 1 : cell_size;
        endfunction

        function longint count_for(longint lo, longint hi);
            longint n;
            if (hi - lo <= 0)
                return 1;
            n = (hi - lo + step_size() - 1) / step_size();
            return n > MAX_CELLS ? MAX_CELLS : n;
        endfunction

        function void recount();
            cols = count_for(min_x, max_x);
            rows = count_for(min_y, max_y);
        endfunction

        function longint cell_of(longint pos, longint lo, longint cnt);
            longint c;
            if (pos - lo < 0)
                return 0;
            c = (pos - lo) / step_size();
            return c > cnt - 1 ? cnt - 1 : c;
        endfunction

        function void set_reg(reg_idx_t idx, logic [COORD_W-1:0] data);
            case (idx)
                REG_MIN_X: min_x     = longint'($signed(data));
                REG_MIN_Y: min_y     = longint'($signed(data));
                REG_MAX_X: max_x     = longint'($signed(data));
                REG_MAX_Y: max_y     = longint'($signed(data));
                REG_CELL:  cell_size = longint'(data[CS_W-1:0]);
                default: ;
            endcase
            recount();
        endfunction

        function void note_query(query_t q);
            cell_span_t s;
            longint     fx, fy, sx, sy, r, x0, y0, x1, y1, c0, r0, c1, r1;
            fx = q.fx;
            fy = q.fy;
            sx = q.sx;
            sy = q.sy;
            r  = longint'(q.rad);
            s  = '{default: 0};
            if (q.fn == FN_POINT)
            begin
                c0 = cell_of(fx, min_x, cols);
                r0 = cell_of(fy, min_y, rows);
                c1 = c0;
                r1 = r0;
            end
            else if (q.fn == FN_INDEX)
            begin
                c0 = fx < 0 ? 0 : (fx > cols - 1 ? cols - 1 : fx);
                r0 = fy < 0 ? 0 : (fy > rows - 1 ? rows - 1 : fy);
                c1 = c0;
                r1 = r0;
            end
            else
            begin
                if (q.fn == FN_BOX)
                begin
                    x0 = fx;
                    y0 = fy;
                    x1 = sx;
                    y1 = sy;
                end
                else
                begin
                    x0 = fx - r;
                    y0 = fy - r;
                    x1 = fx + r;
                    y1 = fy + r;
                end
                if (x1 < min_x || x0 > max_x || y1 < min_y || y0 > max_y)
                begin
                    misses++;
                    spans_due.push_back(s);
                    return;
                end
                c0 = cell_of(x0, min_x, cols);
                r0 = cell_of(y0, min_y, rows);
                c1 = cell_of(x1, min_x, cols);
                r1 = cell_of(y1, min_y, rows);
            end
            s.in_range = 1'b1;
            s.lc = CELL_W'(c0);
            s.lr = CELL_W'(r0);
            s.hc = CELL_W'(c1);
            s.hr = CELL_W'(r1);
            s.li = INDEX_W'(r0 * cols + c0);
            s.hi = INDEX_W'(r1 * cols + c1);
            spans_due.push_back(s);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_span(cell_span_t g);
            cell_span_t e;
            if (spans_due.size() == 0)
            begin
                report("unexpected result, in_range", g.in_range, 0);
                return;
            end
            e = spans_due.pop_front();
            matched++;
            if (g.in_range !== e.in_range) report("in_range", g.in_range, e.in_range);
            if (g.lc !== e.lc) report("low_col", g.lc, e.lc);
            if (g.lr !== e.lr) report("low_row", g.lr, e.lr);
            if (g.hc !== e.hc) report("high_col", g.hc, e.hc);
            if (g.hr !== e.hr) report("high_row", g.hr, e.hr);
            if (g.li !== e.li) report("low_index", g.li, e.li);
            if (g.hi !== e.hi) report("high_index", g.hi, e.hi);
        endtask
    endclass

    logic                      clk, rst_n;
    logic                      cfg_write;
    logic [IDX_W-1:0]          cfg_index;
    logic [COORD_W-1:0]        cfg_data;
    logic                      in_valid, in_stall, out_valid, out_stall;
    logic [1:0]                func;
    logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
    logic [CS_W-1:0]           radius;
    logic                      in_range;
    logic [CELL_W-1:0]         low_col, low_row, high_col, high_row;
    logic [INDEX_W-1:0]        low_index, high_index;

    uniform_grid_cell_mapper dut (.*);

    grid_scoreboard sb = new();
    int sent, cfg_writes, burst_left, stall_pct, hold_req, idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int run_left, hold_left;
        run_left  = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (run_left > 0)
                run_left--;
            else
            begin
                out_stall = ($urandom_range(0, 99) < stall_pct);
                run_left  = $urandom_range(0, 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_span('{in_range, low_col, low_row, high_col, high_row,
                                low_index, high_index});
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 3000)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task send(query_t q);
        @(negedge clk);
        in_valid = 1'b1;
        func     = q.fn;
        first_x  = q.fx;
        first_y  = q.fy;
        second_x = q.sx;
        second_y = q.sy;
        radius   = q.rad;
        do @(posedge clk); while (in_stall);
        sb.note_query(q);
        sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
    endtask

    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.spans_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task write_reg(reg_idx_t idx, logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.set_reg(idx, data);
        cfg_writes++;
    endtask

    task set_area(longint mnx, longint mny, longint mxx, longint mxy,
                  logic [COORD_W-1:0] cs);
        write_reg(REG_MIN_X, COORD_W'(mnx));
        write_reg(REG_MIN_Y, COORD_W'(mny));
        write_reg(REG_MAX_X, COORD_W'(mxx));
        write_reg(REG_MAX_Y, COORD_W'(mxy));
        write_reg(REG_CELL, cs);
    endtask

    function automatic longint clip(longint v);
        return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
    endfunction

    function automatic longint pick_coord(longint lo, longint hi);
        longint a, b, span;
        a    = lo < hi ? lo : hi;
        b    = lo < hi ? hi : lo;
        span = b - a + 1;
        case ($urandom_range(0, 9))
            0, 1: return longint'($signed(COORD_W'($urandom)));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return -8388608;
                    1: return 8388607;
                    2: return a;
                    3: return b;
                    default: return 0;
                endcase
            end
            default: return clip(a - span / 4 + longint'($urandom_range(0, span + span / 2)));
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        longint cs;
        q.fn = func_t'($urandom_range(0, 3));
        cs   = sb.step_size();
        if (q.fn == FN_INDEX && $urandom_range(0, 3) != 0)
        begin
            q.fx = COORD_W'(longint'($urandom_range(0, sb.cols + 3)) - 2);
            q.fy = COORD_W'(longint'($urandom_range(0, sb.rows + 3)) - 2);
        end
        else
        begin
            q.fx = COORD_W'(pick_coord(sb.min_x, sb.max_x));
            q.fy = COORD_W'(pick_coord(sb.min_y, sb.max_y));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            q.sx = COORD_W'(pick_coord(sb.min_x, sb.max_x));
            q.sy = COORD_W'(pick_coord(sb.min_y, sb.max_y));
        end
        else
        begin
            q.sx = COORD_W'(clip(longint'(q.fx) + $urandom_range(0, 4 * cs) - cs / 2));
            q.sy = COORD_W'(clip(longint'(q.fy) + $urandom_range(0, 4 * cs) - cs / 2));
        end
        if ($urandom_range(0, 3) == 0)
            q.rad = CS_W'($urandom);
        else
            q.rad = CS_W'(clip($urandom_range(0, 3 * cs)));
        return q;
    endfunction

    task run_random(int n);
        repeat (n) send(random_query());
    endtask

    task directed_queries();
        query_t d[$];
        d.push_back('{FN_POINT, 0, 0, 0, 0, 0});
        d.push_back('{FN_POINT, -8388608, 8388607, 8388607, -8388608, 0});
        d.push_back('{FN_POINT, 1048575, 1048576, 0, 0, 0});
        d.push_back('{FN_POINT, 257, 511, 0, 0, 23'h7fffff});
        d.push_back('{FN_BOX, 1000, 2000, 30000, 40000, 0});
        d.push_back('{FN_BOX, -5000, 100, -1, 900, 0});
        d.push_back('{FN_BOX, -5000, -5000, 0, 0, 0});
        d.push_back('{FN_BOX, 1048576, 1048576, 2000000, 2000000, 0});
        d.push_back('{FN_BOX, 1048577, 0, 2000000, 100, 0});
        d.push_back('{FN_BOX, 90000, 80000, 1000, 2000, 0});
        d.push_back('{FN_BOX, -8388608, -8388608, 8388607, 8388607, 0});
        d.push_back('{FN_CIRCLE, 524288, 524288, 0, 0, 0});
        d.push_back('{FN_CIRCLE, -8388608, -8388608, 0, 0, 23'h7fffff});
        d.push_back('{FN_CIRCLE, 8388607, 8388607, 0, 0, 23'h7fffff});
        d.push_back('{FN_CIRCLE, -3000, 500, 0, 0, 2999});
        d.push_back('{FN_CIRCLE, -3000, 500, 0, 0, 3000});
        d.push_back('{FN_INDEX, 0, 0, 0, 0, 0});
        d.push_back('{FN_INDEX, 4095, 4095, 0, 0, 0});
        d.push_back('{FN_INDEX, -1, -5, 0, 0, 0});
        d.push_back('{FN_INDEX, 8388607, 5000, 0, 0, 0});
        d.push_back('{FN_INDEX, 10, 20, 0, 0, 0});
        foreach (d[i])
            send(d[i]);
    endtask

    initial
    begin
        longint mnx, mny, cs;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = '0;
        first_x    = '0;
        first_y    = '0;
        second_x   = '0;
        second_y   = '0;
        radius     = '0;
        stall_pct  = 30;
        hold_req   = 0;
        burst_left = 5;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_queries();
        run_random(40);
        drain();

        set_area(-1000, -500, 3000, 2000, 300);
        directed_queries();
        run_random(40);
        drain();

        stall_pct = 0;
        set_area(-8388608, -8388608, 8388607, 8388607, 1);
        run_random(50);
        drain();

        // empty and inverted area, zero cell size
        stall_pct = 60;
        set_area(500, 100, -200, 100, 0);
        run_random(40);
        drain();

        // widest cell, top data bit beyond the register
        stall_pct = 20;
        set_area(-8388608, 0, 8388607, 5000, 24'hffffff);
        run_random(40);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            cs   = $urandom_range(1, 2000);
            mnx  = longint'($signed(COORD_W'($urandom)));
            mny  = longint'($signed(COORD_W'($urandom)));
            stall_pct = $urandom_range(0, 70);
            set_area(mnx, mny, clip(mnx + $urandom_range(0, 20 * cs)),
                     clip(mny + $urandom_range(0, 20 * cs)), COORD_W'(cs));
            if (p == 3)
            begin
                // long output hold-off while input keeps coming
                hold_req   = 300;
                burst_left = 1000;
                run_random(60);
                burst_left = 5;
            end
            else
                run_random(50);
            drain();
        end

        $display("%0d queries sent over %0d register writes, %0d results checked,",
                 sent, cfg_writes, sb.matched);
        $display("%0d boxes outside the area; default, saturated, empty and random grids",
                 sb.misses);
        if (sb.errors == 0 && sb.spans_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
